FILE: design/lobm_pkg.sv
// Shared types and constants of the limit order book matcher.
`default_nettype none
package lobm_pkg;

  localparam int DEF_BOOK_DEPTH      = 16;
  localparam int DEF_NUM_INSTRUMENTS = 5;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 128;
  localparam int CFG_IDX_W  = 2;
  localparam int QTY_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_QTY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_QTY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOT     = 2'd2;

  localparam logic [1:0] SIDE_BUY  = 2'd1;
  localparam logic [1:0] SIDE_SELL = 2'd2;

  localparam logic [1:0] ST_NEW     = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_FILL    = 2'd2;
  localparam logic [1:0] ST_PARTIAL = 2'd3;

  localparam logic [2:0] RSN_OK     = 3'd0;
  localparam logic [2:0] RSN_FIELDS = 3'd1;
  localparam logic [2:0] RSN_INSTR  = 3'd2;
  localparam logic [2:0] RSN_SIDE   = 3'd3;
  localparam logic [2:0] RSN_PRICE  = 3'd4;
  localparam logic [2:0] RSN_SIZE   = 3'd5;

  typedef enum logic [1:0] {
    ADDR_OPP_HEAD, ADDR_OPP_IDX, ADDR_OWN_IDX, ADDR_OWN_IDXM1
  } addr_sel_e;

  typedef enum logic [2:0] {
    WR_NONE, WR_HEAD_QTY, WR_SHIFT_UP, WR_SHIFT_DN, WR_NEW
  } wr_sel_e;

  typedef enum logic [2:0] {
    PEND_NONE, PEND_REJ, PEND_NEW, PEND_IN, PEND_RS
  } pend_op_e;

  typedef enum logic [2:0] {
    IDX_HOLD, IDX_ZERO, IDX_ONE, IDX_INC, IDX_DEC, IDX_FILL
  } idx_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_DEC_OPP, CNT_INC_OWN
  } cnt_op_e;

  typedef struct packed {
    logic      load;
    logic      div_start;
    logic      div_step;
    logic      rd_en;
    addr_sel_e addr_sel;
    wr_sel_e   wr_sel;
    logic      match_calc;
    logic      apply_match;
    pend_op_e  pend_op;
    logic      flush;
    logic      flush_ovf;
    idx_op_e   idx_op;
    logic      pos_set;
    cnt_op_e   cnt_op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] reason_pre;
    logic       div_done;
    logic       size_bad;
    logic       out_free;
    logic       pend_v;
    logic       rem_zero;
    logic       opp_empty;
    logic       crosses;
    logic       rq_zero;
    logic       idx_lt_oppn;
    logic       idx_eq_ownn;
    logic       idx_gt_pos;
    logic       own_full;
    logic       ins_break;
  } status_t;

endpackage
`default_nettype wire

FILE: design/limit_order_book_matcher.sv
// Top level of the price-time priority limit order matcher.
// One order is taken at a time; s_axis_tready is high only while the block waits
// for an order, and reports queue through a held-back report and an output register.
// An order that fails a field check is rejected without the size check. An order that
// passes is checked on size, with the 16-step remainder unit for the lot check. An
// accepted order is then matched against the opposite book, one match at a time, until
// it is filled, the book is empty or the best price does not cross. When a resting order
// is used up, the entries behind it are moved up. A remainder is rested by searching its
// own book for its place and moving the entries behind it down. The book memory is used
// for one read or one write a cycle. A stalled report stream stalls the block. The book
// memory needs no clearing after reset, only the per-book fill counts are reset.
`default_nettype none
module limit_order_book_matcher
  import lobm_pkg::*;
#(
  parameter int BOOK_DEPTH      = DEF_BOOK_DEPTH,
  parameter int NUM_INSTRUMENTS = DEF_NUM_INSTRUMENTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // client_tag[31:0], instrument[34:32], side[36:35], price[68:37], quantity[84:69]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // fields_complete[0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // order_number[31:0], report_client[63:32], report_instrument[66:64],
  // report_side[68:67], exec_qty[84:69], exec_price[116:85], reason[119:117],
  // book_overflow[120]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // exec_status[1:0]
  output logic [1:0]            m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [QTY_W-1:0]      cfg_data_i
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready_o = 1'b1;

  lobm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lobm_dp #(
    .BOOK_DEPTH      (BOOK_DEPTH),
    .NUM_INSTRUMENTS (NUM_INSTRUMENTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_complete_i (s_axis_tuser),
    .in_client_i   (s_axis_tdata[31:0]),
    .in_instr_i    (s_axis_tdata[34:32]),
    .in_side_i     (s_axis_tdata[36:35]),
    .in_price_i    ($signed(s_axis_tdata[68:37])),
    .in_qty_i      (s_axis_tdata[84:69]),
    .cfg_we_i      (cfg_valid_i),
    .cfg_idx_i     (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_data_o    (m_axis_tdata),
    .out_user_o    (m_axis_tuser),
    .out_last_o    (m_axis_tlast)
  );

endmodule
`default_nettype wire

FILE: design/lobm_ctrl.sv
// Sequencing state machine of the order matcher.
`default_nettype none
module lobm_ctrl
  import lobm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHK  = 5'd1;
  localparam logic [4:0] S_DIV  = 5'd2;
  localparam logic [4:0] S_SZ   = 5'd3;
  localparam logic [4:0] S_REJ  = 5'd4;
  localparam logic [4:0] S_FLR  = 5'd5;
  localparam logic [4:0] S_MH   = 5'd6;
  localparam logic [4:0] S_MR   = 5'd7;
  localparam logic [4:0] S_EI   = 5'd8;
  localparam logic [4:0] S_ER   = 5'd9;
  localparam logic [4:0] S_UP   = 5'd10;
  localparam logic [4:0] S_SR   = 5'd11;
  localparam logic [4:0] S_SW   = 5'd12;
  localparam logic [4:0] S_END  = 5'd13;
  localparam logic [4:0] S_FL   = 5'd14;
  localparam logic [4:0] S_IS   = 5'd15;
  localparam logic [4:0] S_IC   = 5'd16;
  localparam logic [4:0] S_DS   = 5'd17;
  localparam logic [4:0] S_DW   = 5'd18;

  logic [4:0] state_q, state_d;
  logic       can_pend;

  assign in_ready_o = (state_q == S_IDLE);
  assign can_pend   = !sts_i.pend_v || sts_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.reason_pre != RSN_OK) begin
          state_d = S_REJ;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_SZ;
        else cmd_o.div_step = 1'b1;
      end
      S_SZ: begin
        state_d = sts_i.size_bad ? S_REJ : S_MH;
      end
      S_REJ: begin
        if (can_pend) begin
          cmd_o.pend_op = PEND_REJ;
          state_d       = S_FLR;
        end
      end
      S_FLR: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_MH: begin
        if (sts_i.rem_zero || sts_i.opp_empty) begin
          state_d = S_END;
        end else begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = ADDR_OPP_HEAD;
          state_d        = S_MR;
        end
      end
      S_MR: begin
        if (!sts_i.crosses) begin
          state_d = S_END;
        end else begin
          cmd_o.match_calc = 1'b1;
          state_d          = S_EI;
        end
      end
      S_EI: begin
        if (can_pend) begin
          cmd_o.pend_op = PEND_IN;
          state_d       = S_ER;
        end
      end
      S_ER: begin
        if (can_pend) begin
          cmd_o.pend_op = PEND_RS;
          state_d       = S_UP;
        end
      end
      S_UP: begin
        cmd_o.apply_match = 1'b1;
        if (sts_i.rq_zero) begin
          cmd_o.idx_op = IDX_ONE;
          state_d      = S_SR;
        end else begin
          cmd_o.wr_sel = WR_HEAD_QTY;
          state_d      = S_MH;
        end
      end
      S_SR: begin
        if (sts_i.idx_lt_oppn) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = ADDR_OPP_IDX;
          state_d        = S_SW;
        end else begin
          cmd_o.cnt_op = CNT_DEC_OPP;
          state_d      = S_MH;
        end
      end
      S_SW: begin
        cmd_o.wr_sel = WR_SHIFT_UP;
        cmd_o.idx_op = IDX_INC;
        state_d      = S_SR;
      end
      S_END: begin
        if (!sts_i.pend_v) cmd_o.pend_op = PEND_NEW;
        state_d = S_FL;
      end
      S_FL: begin
        if (sts_i.out_free) begin
          cmd_o.flush     = 1'b1;
          cmd_o.flush_ovf = !sts_i.rem_zero && sts_i.own_full;
          if (sts_i.rem_zero || sts_i.own_full) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_op = IDX_ZERO;
            state_d      = S_IS;
          end
        end
      end
      S_IS: begin
        if (sts_i.idx_eq_ownn) begin
          cmd_o.pos_set = 1'b1;
          cmd_o.idx_op  = IDX_FILL;
          state_d       = S_DS;
        end else begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = ADDR_OWN_IDX;
          state_d        = S_IC;
        end
      end
      S_IC: begin
        if (sts_i.ins_break) begin
          cmd_o.pos_set = 1'b1;
          cmd_o.idx_op  = IDX_FILL;
          state_d       = S_DS;
        end else begin
          cmd_o.idx_op = IDX_INC;
          state_d      = S_IS;
        end
      end
      S_DS: begin
        if (sts_i.idx_gt_pos) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = ADDR_OWN_IDXM1;
          state_d        = S_DW;
        end else begin
          cmd_o.wr_sel = WR_NEW;
          cmd_o.cnt_op = CNT_INC_OWN;
          state_d      = S_IDLE;
        end
      end
      S_DW: begin
        cmd_o.wr_sel = WR_SHIFT_DN;
        cmd_o.idx_op = IDX_DEC;
        state_d      = S_DS;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule
`default_nettype wire

FILE: design/lobm_dp.sv
// Datapath: order registers, remainder unit, book memory, report registers.
`default_nettype none
module lobm_dp
  import lobm_pkg::*;
#(
  parameter int BOOK_DEPTH      = DEF_BOOK_DEPTH,
  parameter int NUM_INSTRUMENTS = DEF_NUM_INSTRUMENTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               sts_o,
  input  logic                  in_complete_i,
  input  logic [31:0]           in_client_i,
  input  logic [2:0]            in_instr_i,
  input  logic [1:0]            in_side_i,
  input  logic signed [31:0]    in_price_i,
  input  logic [QTY_W-1:0]      in_qty_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [QTY_W-1:0]      cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic [1:0]            out_user_o,
  output logic                  out_last_o
);

  localparam int NBOOKS = 2 * NUM_INSTRUMENTS;
  localparam int NSLOTS = NBOOKS * BOOK_DEPTH;
  localparam int AW     = $clog2(NSLOTS);
  localparam int BW     = $clog2(NBOOKS);
  localparam int CW     = $clog2(BOOK_DEPTH + 1);

  typedef struct packed {
    logic signed [31:0] price;
    logic [QTY_W-1:0]   qty;
    logic [31:0]        client;
    logic [31:0]        onum;
  } entry_t;

  typedef struct packed {
    logic [31:0]        onum;
    logic [31:0]        client;
    logic [2:0]         instr;
    logic [1:0]         side;
    logic [1:0]         status;
    logic [QTY_W-1:0]   qty;
    logic signed [31:0] price;
    logic [2:0]         reason;
  } report_t;

  // order and configuration
  logic               complete_q;
  logic [31:0]        client_q, num_q, next_num_q;
  logic [2:0]         instr_q;
  logic [1:0]         side_q;
  logic signed [31:0] price_q;
  logic [QTY_W-1:0]   qty_q, remaining_q;
  logic [QTY_W-1:0]   min_q, max_q, lot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_num_q <= 32'd1;
      min_q      <= 16'd10;
      max_q      <= 16'd1000;
      lot_q      <= 16'd10;
    end else begin
      if (cmd_i.load) next_num_q <= next_num_q + 32'd1;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_QTY: min_q <= cfg_data_i;
          CFG_MAX_QTY: max_q <= cfg_data_i;
          CFG_LOT:     lot_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  logic [QTY_W-1:0] m_q, rq_new_q;
  logic [1:0]       st_in_q, st_rs_q;
  entry_t           rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      complete_q  <= in_complete_i;
      client_q    <= in_client_i;
      instr_q     <= in_instr_i;
      side_q      <= in_side_i;
      price_q     <= in_price_i;
      qty_q       <= in_qty_i;
      remaining_q <= in_qty_i;
      num_q       <= next_num_q;
    end else if (cmd_i.apply_match) begin
      remaining_q <= remaining_q - m_q;
    end
  end

  logic [2:0] reason_pre;
  always_comb begin
    if (!complete_q) reason_pre = RSN_FIELDS;
    else if (32'(instr_q) >= NUM_INSTRUMENTS) reason_pre = RSN_INSTR;
    else if (side_q != SIDE_BUY && side_q != SIDE_SELL) reason_pre = RSN_SIDE;
    else if (price_q <= 32'sd0) reason_pre = RSN_PRICE;
    else reason_pre = RSN_OK;
  end

  // bit-serial remainder of quantity by lot size
  logic [QTY_W-1:0] rem_q, dq_q;
  logic [4:0]       dcnt_q;
  logic [QTY_W:0]   rem2;
  assign rem2 = {rem_q, dq_q[QTY_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= 5'(QTY_W);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      dq_q  <= qty_q;
    end else if (cmd_i.div_step) begin
      dq_q <= {dq_q[QTY_W-2:0], 1'b0};
      if (rem2 >= {1'b0, lot_q}) rem_q <= QTY_W'(rem2 - {1'b0, lot_q});
      else rem_q <= rem2[QTY_W-1:0];
    end
  end

  // book addressing
  logic          opp_bit;
  logic [3:0]    opp_vec, own_vec;
  logic [BW-1:0] opp_book, own_book;
  logic [AW-1:0] opp_base, own_base;
  logic [CW-1:0] cnt_q [NBOOKS];
  logic [CW-1:0] opp_n, own_n, idx_q, pos_q;

  assign opp_bit  = (side_q == SIDE_BUY);
  assign opp_vec  = {instr_q, opp_bit};
  assign own_vec  = {instr_q, !opp_bit};
  assign opp_book = opp_vec[BW-1:0];
  assign own_book = own_vec[BW-1:0];
  assign opp_base = AW'(opp_book) * AW'(BOOK_DEPTH);
  assign own_base = AW'(own_book) * AW'(BOOK_DEPTH);
  assign opp_n    = cnt_q[opp_book];
  assign own_n    = cnt_q[own_book];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NBOOKS; b++) cnt_q[b] <= '0;
    end else begin
      case (cmd_i.cnt_op)
        CNT_DEC_OPP: cnt_q[opp_book] <= opp_n - CW'(1);
        CNT_INC_OWN: cnt_q[own_book] <= own_n + CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.idx_op)
      IDX_ZERO: idx_q <= '0;
      IDX_ONE:  idx_q <= CW'(1);
      IDX_INC:  idx_q <= idx_q + CW'(1);
      IDX_DEC:  idx_q <= idx_q - CW'(1);
      IDX_FILL: idx_q <= own_n;
      default: ;
    endcase
    if (cmd_i.pos_set) pos_q <= idx_q;
  end

  // book memory, one read and one write port
  entry_t        mem [NSLOTS];
  logic [AW-1:0] raddr, waddr;
  logic          we;
  entry_t        wdata;

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_OPP_HEAD:  raddr = opp_base;
      ADDR_OPP_IDX:   raddr = opp_base + AW'(idx_q);
      ADDR_OWN_IDX:   raddr = own_base + AW'(idx_q);
      ADDR_OWN_IDXM1: raddr = own_base + AW'(idx_q) - AW'(1);
      default:        raddr = opp_base;
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = opp_base;
    wdata = rd_q;
    case (cmd_i.wr_sel)
      WR_HEAD_QTY: wdata.qty = rq_new_q;
      WR_SHIFT_UP: waddr = opp_base + AW'(idx_q) - AW'(1);
      WR_SHIFT_DN: waddr = own_base + AW'(idx_q);
      WR_NEW: begin
        waddr = own_base + AW'(pos_q);
        wdata = '{price: price_q, qty: remaining_q, client: client_q, onum: num_q};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.rd_en) rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.match_calc) begin
      m_q      <= (remaining_q < rd_q.qty) ? remaining_q : rd_q.qty;
      rq_new_q <= (remaining_q < rd_q.qty) ? rd_q.qty - remaining_q : '0;
      st_in_q  <= (remaining_q > rd_q.qty) ? ST_PARTIAL : ST_FILL;
      st_rs_q  <= (rd_q.qty > remaining_q) ? ST_PARTIAL : ST_FILL;
    end
  end

  // held-back report and output register
  report_t pend_q, pend_d, out_q;
  logic    pend_v_q, out_v_q, out_last_q, out_ovf_q, push, out_free;

  always_comb begin
    pend_d = '{onum: num_q, client: client_q, instr: instr_q, side: side_q,
               status: ST_NEW, qty: qty_q, price: price_q, reason: RSN_OK};
    case (cmd_i.pend_op)
      PEND_REJ: begin
        pend_d.status = ST_REJECT;
        pend_d.reason = (reason_pre != RSN_OK) ? reason_pre : RSN_SIZE;
      end
      PEND_IN: begin
        pend_d.status = st_in_q;
        pend_d.qty    = m_q;
        pend_d.price  = rd_q.price;
      end
      PEND_RS: begin
        pend_d.onum   = rd_q.onum;
        pend_d.client = rd_q.client;
        pend_d.side   = (side_q == SIDE_BUY) ? SIDE_SELL : SIDE_BUY;
        pend_d.status = st_rs_q;
        pend_d.qty    = m_q;
        pend_d.price  = rd_q.price;
      end
      default: ;
    endcase
  end

  assign push     = cmd_i.flush || (cmd_i.pend_op != PEND_NONE && pend_v_q);
  assign out_free = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.flush) pend_v_q <= 1'b0;
      else if (cmd_i.pend_op != PEND_NONE) pend_v_q <= 1'b1;
      if (push) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_op != PEND_NONE) pend_q <= pend_d;
    if (push) begin
      out_q      <= pend_q;
      out_last_q <= cmd_i.flush;
      out_ovf_q  <= cmd_i.flush && cmd_i.flush_ovf;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_user_o  = out_q.status;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {7'd0, out_ovf_q, out_q.reason, out_q.price, out_q.qty,
                        out_q.side, out_q.instr, out_q.client, out_q.onum};

  always_comb begin
    sts_o.reason_pre  = reason_pre;
    sts_o.div_done    = (dcnt_q == 5'd0);
    sts_o.size_bad    = (lot_q != '0 && rem_q != '0) || qty_q < min_q || qty_q > max_q;
    sts_o.out_free    = out_free;
    sts_o.pend_v      = pend_v_q;
    sts_o.rem_zero    = (remaining_q == '0);
    sts_o.opp_empty   = (opp_n == '0);
    sts_o.crosses     = (side_q == SIDE_BUY) ? (rd_q.price <= price_q)
                                             : (rd_q.price >= price_q);
    sts_o.rq_zero     = (rq_new_q == '0);
    sts_o.idx_lt_oppn = (idx_q < opp_n);
    sts_o.idx_eq_ownn = (idx_q == own_n);
    sts_o.idx_gt_pos  = (idx_q > pos_q);
    sts_o.own_full    = (own_n == CW'(BOOK_DEPTH));
    sts_o.ins_break   = (side_q == SIDE_BUY) ? (rd_q.price < price_q)
                                             : (rd_q.price > price_q);
  end

endmodule
`default_nettype wire

FILE: design/lobm_checker.sv
// Port-level checks on the report stream of the order matcher.
`default_nettype none
module lobm_checker
  import lobm_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]            m_axis_tuser,
  input logic                  m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled report changed");

  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_REJECT |-> m_axis_tlast && !m_axis_tdata[120])
    else $error("reject not a lone final report");

  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[120] |-> m_axis_tlast)
    else $error("overflow flag off the final report");

  a_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == ST_REJECT) == (m_axis_tdata[119:117] != RSN_OK)))
    else $error("reason code does not match status");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench of the limit order book matcher: random and directed orders.
`default_nettype none
module tb;
  import lobm_pkg::*;

  localparam int DEPTH  = DEF_BOOK_DEPTH;
  localparam int NINSTR = DEF_NUM_INSTRUMENTS;
  localparam int NBOOKS = 2 * NINSTR;
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic        complete;
    logic [31:0] client;
    logic [2:0]  instr;
    logic [1:0]  side;
    logic [31:0] price;
    logic [15:0] qty;
  } order_t;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] client;
    logic [2:0]  instr;
    logic [1:0]  side;
    logic [1:0]  status;
    logic [15:0] qty;
    logic [31:0] price;
    logic [2:0]  reason;
    logic        ovf;
    logic        last;
  } report_t;

  typedef struct packed {
    logic [31:0] price;
    logic [15:0] qty;
    logic [31:0] client;
    logic [31:0] num;
  } entry_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0, s_axis_tuser = 1'b0, m_axis_tready = 1'b0;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tready, m_axis_tvalid, m_axis_tlast, cfg_ready_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [QTY_W-1:0] cfg_data_i = '0;

  limit_order_book_matcher DUT (.*);

  order_t  pending_orders[$];
  report_t expected_reports[$];
  entry_t  book[NBOOKS][$];
  logic [31:0] next_num;
  logic [15:0] min_qty, max_qty, lot;
  int errors = 0;
  longint cycles = 0;
  int burst_left = 0, gap_left = 0;
  bit hold_tx = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic report_t mk(logic [31:0] num, logic [31:0] client, logic [2:0] instr,
                                 logic [1:0] side, logic [1:0] st, logic [15:0] qty,
                                 logic [31:0] price, logic [2:0] rsn);
    report_t r;
    r = '{num, client, instr, side, st, qty, price, rsn, 1'b0, 1'b0};
    return r;
  endfunction

  // Check the order, match, then rest the remainder; queues the reports the order causes.
  task automatic match_order(order_t o);
    logic [31:0] num;
    logic [2:0] rsn;
    int opp, own, pos, k;
    int unsigned rem, rq, m;
    bit ovf, crosses;
    report_t r;
    entry_t e;
    num = next_num;
    next_num = next_num + 1;
    k = 0;
    ovf = 0;
    if (!o.complete) rsn = RSN_FIELDS;
    else if (o.instr >= NINSTR) rsn = RSN_INSTR;
    else if (o.side != SIDE_BUY && o.side != SIDE_SELL) rsn = RSN_SIDE;
    else if ($signed(o.price) <= 0) rsn = RSN_PRICE;
    else if ((lot != 0 && o.qty % lot != 0) || o.qty < min_qty || o.qty > max_qty)
      rsn = RSN_SIZE;
    else rsn = RSN_OK;
    if (rsn != RSN_OK) begin
      r = mk(num, o.client, o.instr, o.side, ST_REJECT, o.qty, o.price, rsn);
      r.last = 1'b1;
      expected_reports = {expected_reports, r};
      return;
    end
    opp = o.instr * 2 + (o.side == SIDE_BUY ? 1 : 0);
    own = o.instr * 2 + (o.side == SIDE_BUY ? 0 : 1);
    rem = o.qty;
    while (rem > 0 && book[opp].size() > 0) begin
      e = book[opp][0];
      rq = e.qty;
      crosses = (o.side == SIDE_BUY) ? ($signed(e.price) <= $signed(o.price))
                                     : ($signed(e.price) >= $signed(o.price));
      if (!crosses) break;
      m = rem < rq ? rem : rq;
      expected_reports = {expected_reports, mk(num, o.client, o.instr, o.side,
        rem > rq ? ST_PARTIAL : ST_FILL, m[15:0], e.price, RSN_OK)};
      expected_reports = {expected_reports, mk(e.num, e.client, o.instr,
        o.side == SIDE_BUY ? SIDE_SELL : SIDE_BUY,
        rq > rem ? ST_PARTIAL : ST_FILL, m[15:0], e.price, RSN_OK)};
      k += 2;
      rem -= m;
      rq -= m;
      if (rq == 0) void'(book[opp].pop_front());
      else book[opp][0].qty = rq[15:0];
    end
    if (k == 0) expected_reports = {expected_reports, mk(num, o.client, o.instr, o.side,
                                                         ST_NEW, o.qty, o.price, RSN_OK)};
    if (rem > 0) begin
      if (book[own].size() >= DEPTH) ovf = 1;
      else begin
        pos = 0;
        while (pos < book[own].size()) begin
          if (o.side == SIDE_BUY ? $signed(book[own][pos].price) < $signed(o.price)
                                 : $signed(book[own][pos].price) > $signed(o.price)) break;
          pos++;
        end
        e = '{o.price, rem[15:0], o.client, num};
        book[own].insert(pos, e);
      end
    end
    r = expected_reports.pop_back();
    r.ovf = ovf;
    r.last = 1'b1;
    expected_reports = {expected_reports, r};
  endtask

  // Driver: bursts and gaps on the order stream.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) match_order(pending_orders.pop_front());
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0 || hold_tx || pending_orders.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= pending_orders[0].complete;
          s_axis_tdata  <= {3'b0, pending_orders[0].qty, pending_orders[0].price,
                            pending_orders[0].side, pending_orders[0].instr,
                            pending_orders[0].client};
          if (burst_left == 0) begin
            burst_left <= $urandom_range(8, 1);
            gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 1);
          end else burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Monitor and receiver stall pattern.
  always @(posedge clk_i) begin
    report_t got, want;
    if (rst_ni) begin
      m_axis_tready <= (cycles % 1000 < 300) ? 1'b1 : ($urandom_range(3) != 0);
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[66:64],
                m_axis_tdata[68:67], m_axis_tuser, m_axis_tdata[84:69],
                m_axis_tdata[116:85], m_axis_tdata[119:117], m_axis_tdata[120],
                m_axis_tlast};
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report %h", $time, got);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            $display("%0t: report mismatch expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
    end
  end

  function automatic order_t valid_order(int instr, logic [1:0] side, int base);
    order_t o;
    int unsigned q;
    o.complete = 1'b1;
    o.client = $urandom;
    o.instr = 3'(instr);
    o.side = side;
    o.price = base + $urandom_range(8) - 4;
    q = lot * $urandom_range(max_qty / (lot == 0 ? 1 : lot),
                             (min_qty + lot - 1) / (lot == 0 ? 1 : lot));
    o.qty = q[15:0];
    return o;
  endfunction

  task automatic wait_idle();
    while (pending_orders.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    hold_tx = 1'b1;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    hold_tx = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MIN_QTY: min_qty = val;
      CFG_MAX_QTY: max_qty = val;
      default:     lot = val;
    endcase
    @(posedge clk_i);
  endtask

  initial begin
    order_t o;
    logic [95:0] rnd;
    int n;
    next_num = 1;
    min_qty = 10;
    max_qty = 1000;
    lot = 10;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: each reject reason, extremes, full book, overflow
    o = '{1'b0, 32'hFFFF_FFFF, 3'd7, 2'd3, 32'h8000_0000, 16'hFFFF};
    pending_orders = {pending_orders, o};
    o = '{1'b1, 32'h0, 3'd5, 2'd1, 32'd100, 16'd10}; pending_orders = {pending_orders, o};
    o = '{1'b1, 32'h1, 3'd0, 2'd0, 32'd100, 16'd10}; pending_orders = {pending_orders, o};
    o = '{1'b1, 32'h2, 3'd0, 2'd3, 32'd100, 16'd10}; pending_orders = {pending_orders, o};
    o = '{1'b1, 32'h3, 3'd1, 2'd1, 32'd0,   16'd10}; pending_orders = {pending_orders, o};
    o = '{1'b1, 32'h4, 3'd1, 2'd1, 32'h7FFF_FFFF, 16'd15};
    pending_orders = {pending_orders, o};
    o = '{1'b1, 32'h5, 3'd1, 2'd1, 32'd50, 16'd0}; pending_orders = {pending_orders, o};
    o = '{1'b1, 32'h6, 3'd1, 2'd1, 32'd50, 16'd1010}; pending_orders = {pending_orders, o};
    for (int i = 0; i < 17; i++) begin
      o = '{1'b1, 32'hA000 + i, 3'd4, SIDE_SELL, 32'd200 + (i % 3), 16'd10};
      pending_orders = {pending_orders, o};
    end
    o = '{1'b1, 32'hBEEF, 3'd4, SIDE_BUY, 32'h7FFF_FFFF, 16'd1000};
    pending_orders = {pending_orders, o};
    wait_idle();
    write_reg(CFG_MIN_QTY, 16'd0);
    write_reg(CFG_MAX_QTY, 16'hFFFF);
    write_reg(CFG_LOT, 16'd0);
    o = '{1'b1, 32'h7, 3'd2, SIDE_BUY, 32'd5, 16'd0}; pending_orders = {pending_orders, o};
    o = '{1'b1, 32'h8, 3'd2, SIDE_SELL, 32'd5, 16'hFFFF};
    pending_orders = {pending_orders, o};
    o = '{1'b1, 32'h9, 3'd2, SIDE_BUY, 32'd6, 16'hFFFF}; pending_orders = {pending_orders, o};
    o = '{1'b1, 32'hA, 3'd2, SIDE_BUY, 32'd5, 16'd7}; pending_orders = {pending_orders, o};
    wait_idle();
    // random phases across settings
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin write_reg(CFG_MIN_QTY, 16'd1); write_reg(CFG_MAX_QTY, 16'd200);
                 write_reg(CFG_LOT, 16'd1); end
        1: begin write_reg(CFG_MIN_QTY, 16'd10); write_reg(CFG_MAX_QTY, 16'd1000);
                 write_reg(CFG_LOT, 16'd10); end
        default: begin write_reg(CFG_MIN_QTY, 16'd1); write_reg(CFG_MAX_QTY, 16'd1);
                 write_reg(CFG_LOT, 16'hFFFF); write_reg(CFG_MIN_QTY, 16'd0);
                 write_reg(CFG_MAX_QTY, 16'hFFFF); write_reg(CFG_LOT, 16'd5); end
      endcase
      n = 0;
      while (n < 34) begin
        if ($urandom_range(9) < 8) o = valid_order($urandom_range(1, 0),
            $urandom_range(1) ? SIDE_BUY : SIDE_SELL, 1000);
        else begin
          rnd = {$urandom, $urandom, $urandom};
          o = rnd[85:0];
          o.complete = $urandom_range(4) != 0;
        end
        pending_orders = {pending_orders, o};
        n++;
      end
      wait_idle();
    end
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire

FILE: limit_order_book_matcher.f
design/lobm_pkg.sv
design/lobm_ctrl.sv
design/lobm_dp.sv
design/limit_order_book_matcher.sv
design/lobm_checker.sv
sim/tb.sv
